// ===== hdl/sdm_pkg.sv =====
// shared types, widths and constants for the sigma-delta modulator
// no dependencies; imported by the sample and register-write interfaces and every module
`default_nettype none

package sdm_pkg;

  // integrator state width, valid range 16 to 64
  localparam int STATE_W  = 32;
  localparam int SAMPLE_W = 32;
  // feed-forward sum: widest operand plus headroom for weights up to 8
  localparam int SUM_W    = ((STATE_W > SAMPLE_W) ? STATE_W : SAMPLE_W) + 3;

  localparam int ORDER_W  = 2;
  localparam int FB_W     = 31;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = FB_W;

  // resonator feedback is S3 / 2^RES_SHIFT
  localparam int RES_SHIFT = 8;

  localparam logic [ORDER_W-1:0] ORD_ZERO  = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_ONE   = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_TWO   = 2'd2;
  localparam logic [ORDER_W-1:0] ORD_THREE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_RST = ORD_THREE;
  localparam logic [FB_W-1:0]    FB_RST    = 31'd536870912;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [FB_W-1:0]    feedback_level;
  } cfg_t;

  // v / 2 rounded toward zero
  function automatic logic signed [STATE_W-1:0] half_state(input logic signed [STATE_W-1:0] v);
    logic signed [STATE_W-1:0] t;
    t = v + {{(STATE_W-1){1'b0}}, v[STATE_W-1]};
    return t >>> 1;
  endfunction

  // v / 2^RES_SHIFT rounded toward zero
  function automatic logic signed [STATE_W-1:0] res_state(input logic signed [STATE_W-1:0] v);
    logic signed [STATE_W-1:0] t;
    t = v + {{(STATE_W-RES_SHIFT){1'b0}}, {RES_SHIFT{v[STATE_W-1]}}};
    return t >>> RES_SHIFT;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] half_sample(
    input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] t;
    t = v + {{(SAMPLE_W-1){1'b0}}, v[SAMPLE_W-1]};
    return t >>> 1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sdm_if.sv =====
// valid/ready channel interfaces: sample input, bit output, register writes
// depends on sdm_pkg
`default_nettype none

interface sdm_in_if import sdm_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface sdm_out_if;
  logic valid;
  logic ready;
  logic q_bit;
  modport source (output valid, output q_bit, input ready);
  modport sink   (input valid, input q_bit, output ready);
endinterface

interface sdm_cfg_if import sdm_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sdm_cfg_regs.sv =====
// configuration registers: modulator order and feedback level
// depends on sdm_pkg
`default_nettype none

module sdm_cfg_regs import sdm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.order          <= ORDER_RST;
      cfg_r.feedback_level <= FB_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ORDER:    cfg_r.order          <= wr_data[ORDER_W-1:0];
        REG_FEEDBACK: cfg_r.feedback_level <= wr_data[FB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/sdm_loop.sv =====
// integrator states, feed-forward sum and single-bit quantiser
// depends on sdm_pkg
`default_nettype none

module sdm_loop import sdm_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire cfg_t                       cfg,
  output logic                            q
);

  logic signed [STATE_W-1:0] integ_one_r, integ_two_r, integ_three_r;
  logic signed [STATE_W-1:0] integ_one_nxt, integ_two_nxt, integ_three_nxt;
  logic [ORDER_W-1:0]        ord;
  logic signed [SUM_W-1:0]   x_e, s1_e, s2_e, s3_e, sum;
  logic [STATE_W-1:0]        hx_w, fb_w;

  // order zero runs as first order
  assign ord = (cfg.order == ORD_ZERO) ? ORD_ONE : cfg.order;

  assign x_e  = SUM_W'(sample);
  assign s1_e = SUM_W'(integ_one_r);
  assign s2_e = SUM_W'(integ_two_r);
  assign s3_e = SUM_W'(integ_three_r);

  always_comb begin
    case (ord)
      ORD_TWO:   sum = x_e + (s1_e <<< 1) + s2_e;
      ORD_THREE: sum = x_e + s1_e + (s1_e <<< 1) + s2_e + (s2_e <<< 1) + s3_e;
      default:   sum = x_e + s1_e;
    endcase
  end

  assign q = !sum[SUM_W-1] && (sum != '0);

  // sample / 2 at sample width, then wrapped into the state width
  assign hx_w = STATE_W'(half_sample(sample));
  assign fb_w = STATE_W'(cfg.feedback_level);

  always_comb begin
    integ_one_nxt = q ? (integ_one_r + hx_w - fb_w) : (integ_one_r + hx_w + fb_w);
    integ_two_nxt   = integ_two_r;
    integ_three_nxt = integ_three_r;
    case (ord)
      ORD_TWO: integ_two_nxt = integ_two_r + half_state(integ_one_r);
      ORD_THREE: begin
        integ_three_nxt = integ_three_r + half_state(integ_two_r);
        integ_two_nxt   = integ_two_r + half_state(integ_one_r) - res_state(integ_three_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_one_r   <= '0;
      integ_two_r   <= '0;
      integ_three_r <= '0;
    end else if (adv) begin
      integ_one_r   <= integ_one_nxt;
      integ_two_r   <= integ_two_nxt;
      integ_three_r <= integ_three_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(integ_one_r) && $stable(integ_two_r) && $stable(integ_three_r))
    else $error("integrator state changed without a transaction");
  a_first_order_keeps_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (ord == ORD_ONE)) |=> $stable(integ_two_r) && $stable(integ_three_r))
    else $error("unused stages changed in first order");
  a_third_stage_only_in_third_order: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (ord != ORD_THREE)) |=> $stable(integ_three_r))
    else $error("third stage changed below third order");
`endif

endmodule

`default_nettype wire

// ===== hdl/sigma_delta_modulator_unit.sv =====
// sigma-delta modulator, order 1 to 3, single-bit output
// an accepted sample is registered in the input stage; q_bit is registered from the loop when that stage advances
// throughput: one sample per cycle while the output is not back-pressured, set by the integrator update loop
// reset (synchronous, rst_n low): integrators cleared, order 3, feedback level 2^29
// configuration writes are always accepted; depends on sdm_pkg, sdm_if, sdm_cfg_regs, sdm_loop
`default_nettype none

module sigma_delta_modulator_unit import sdm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sdm_in_if.sink    in_ch,
  sdm_out_if.source out_ch,
  sdm_cfg_if.sink   cfg_ch
);

  logic                       in_vld_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       out_vld_r;
  logic                       q_r;
  logic                       adv;
  logic                       q;
  cfg_t                       cfg;

  // input stage moves on when the result register is empty or being drained
  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld_r;
  assign out_ch.q_bit = q_r;

  sdm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid && cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  sdm_loop u_loop (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .sample (sample_r),
    .cfg    (cfg),
    .q      (q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r <= in_ch.sample_in;
    end
    if (adv) begin
      q_r <= q;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ch.ready)
    else $error("input stage empty but not ready");
  a_block_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("transaction accepted while both stages are stalled");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_ch.valid)
    else $error("processed sample gave no result");
`endif

endmodule

`default_nettype wire
